// ----- rtl/core/tsh_pkg.sv -----
// ----------------------------------------------------------------------------
// tsh_pkg
// Shared types and constants for the thermal severity hysteresis block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsh_pkg;

	// Number of thermal zones that can report; readings from zones at or
	// above this count are dropped.
	localparam int ZONE_COUNT  = 16;
	localparam int LEVEL_COUNT = 6;

	typedef logic signed [18:0] milli_t;
	typedef milli_t thr_arr_t [LEVEL_COUNT];

	localparam milli_t TEMP_LOW     = -19'sd40000;
	localparam milli_t TEMP_HIGH    = 19'sd150000;
	localparam milli_t THR_DISABLED = 19'sd262143;
	localparam logic signed [19:0] NOTIFY_STEP = 20'sd500;

	// Configuration register indexes. Indexes below REG_HYSTERESIS are the
	// six thresholds in rising order.
	localparam logic [2:0] REG_THR_LIGHT  = 3'd0;
	localparam logic [2:0] REG_HYSTERESIS = 3'd6;
	localparam logic [2:0] REG_PRIMARY    = 3'd7;

	localparam logic [15:0] HYST_RESET    = 16'd2000;
	localparam logic [4:0]  PRIMARY_RESET = 5'd16;
	localparam logic [4:0]  PRIMARY_LIMIT = 5'd16;

	typedef struct packed {
		logic [2:0] severity;
		milli_t     temp_milli;
		logic       temp_valid;
		logic       notify;
	} tsh_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/tsh_classify.sv -----
// ----------------------------------------------------------------------------
// tsh_classify
// Maps a chosen temperature to a severity with hysteresis and forms notify.
// ----------------------------------------------------------------------------
`default_nettype none

module tsh_classify
	import tsh_pkg::*;
(
	input  var milli_t      temp,
	input  wire             temp_ok,
	input  wire [2:0]       level,
	input  var thr_arr_t    thr,
	input  wire [15:0]      hyst,
	input  var milli_t      last_temp,
	input  wire             last_ok,
	output tsh_result_t     res
);

	logic [2:0]         sev_raw;
	logic [2:0]         sev;
	logic [2:0]         cur_idx;
	milli_t             thr_cur;
	logic signed [20:0] hold_lim;
	logic signed [19:0] diff;
	logic               big_move;

	// The highest enabled level whose threshold the temperature reaches wins.
	always_comb begin
		sev_raw = 3'd0;
		for (int i = 0; i < LEVEL_COUNT; i++) begin
			if (thr[i] != THR_DISABLED && temp >= thr[i]) begin
				sev_raw = 3'(i + 1);
			end
		end
	end

	assign cur_idx = level - 3'd1;
	assign thr_cur = (level == 3'd0) ? '0 : thr[cur_idx];
	assign hold_lim = 21'(signed'(thr_cur)) - signed'({5'b0, hyst});

	always_comb begin
		sev = 3'd0;
		if (temp_ok) begin
			sev = sev_raw;
			if (sev_raw < level && thr_cur != THR_DISABLED &&
			    21'(signed'(temp)) >= hold_lim) begin
				sev = level;
			end
		end
	end

	assign diff     = 20'(signed'(last_temp)) - 20'(signed'(temp));
	assign big_move = (diff >= NOTIFY_STEP) || (diff <= -NOTIFY_STEP);

	always_comb begin
		res.severity   = sev;
		res.temp_milli = temp;
		res.temp_valid = temp_ok;
		res.notify     = (sev != level) || !last_ok || (temp_ok && big_move);
	end

endmodule

`default_nettype wire

// ----- rtl/core/thermal_severity_hysteresis.sv -----
// ----------------------------------------------------------------------------
// thermal_severity_hysteresis
// Per-poll thermal severity classifier with six thresholds and hysteresis.
// ----------------------------------------------------------------------------
// Usage: zone readings stream in on the s_ channel, one per transaction.
// s_tdata carries the zone index and the signed millidegree reading,
// s_tuser the read-ok flag and s_tlast closes a poll. Every reading that
// read well, comes from a known zone and lies between -40 and 150 degrees
// updates a running maximum and the primary zone capture. The reading with
// s_tlast produces exactly one transaction on the m_ channel with the
// severity, the chosen temperature, the notify flag and (on m_tuser) the
// temperature-valid flag; other readings produce nothing.
// Throughput is one reading per cycle while s_tready is high. A poll result
// reaches m_tvalid through one input register, one register holding the
// chosen temperature, then the output register that also carries the
// severity and notify decision.
// When the receiver stalls the output register holds its result; the
// pipeline keeps accepting readings until a second and third poll result
// fill the two stages behind it, and only then drops s_tready.
// Reset clears the pipeline, the poll accumulators and the severity
// history, loads all thresholds as disabled, hysteresis as 2 degrees and
// primary selection as "take the maximum". Configuration writes go through
// cfg_wen and must happen while no poll is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_severity_hysteresis
	import tsh_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	// Configuration write port.
	input  wire        cfg_wen,
	input  wire [2:0]  cfg_index,
	input  wire [18:0] cfg_wdata,
	// Reading stream.
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [23:0] s_tdata,   // [3:0] zone_index, [22:4] reading_milli, [23] zero
	input  wire        s_tuser,   // [0] read_ok
	input  wire        s_tlast,   // last_of_poll
	// Result stream.
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [23:0] m_tdata,  // [2:0] severity, [21:3] temp_milli, [22] notify,
	                              // [23] zero
	output logic       m_tuser    // [0] temp_valid
);

	// Configuration registers.
	thr_arr_t    thr_q;
	logic [15:0] hyst_q;
	logic [4:0]  primary_q;

	// Stage 1: registered reading.
	logic        vld_s1;
	logic [3:0]  zone_s1;
	milli_t      reading_s1;
	logic        ok_s1;
	logic        last_s1;

	// Poll accumulators.
	milli_t      rmax_q;
	logic        max_seen_q;
	milli_t      prim_q;
	logic        prim_seen_q;

	// Stage 2: chosen temperature of a finished poll.
	logic        vld_s2;
	milli_t      temp_s2;
	logic        temp_ok_s2;

	// Severity history.
	logic [2:0]  level_q;
	milli_t      last_temp_q;
	logic        last_ok_q;

	// Output register.
	logic        out_vld_q;
	tsh_result_t out_q;

	logic        rdy_out, rdy2, fire1, fire2;
	logic        primary_on, reading_good, is_primary;
	milli_t      rmax_nxt, prim_nxt, chosen;
	logic        max_seen_nxt, prim_seen_nxt, chosen_ok;
	tsh_result_t cls_res;

	// Handshake chain: a reading without tlast retires at stage 1 into the
	// accumulators, so only poll-closing readings need room downstream.
	assign rdy_out  = !out_vld_q || m_tready;
	assign rdy2     = !vld_s2 || rdy_out;
	assign fire2    = vld_s2 && rdy_out;
	assign fire1    = vld_s1 && (!last_s1 || rdy2);
	assign s_tready = !vld_s1 || !last_s1 || rdy2;

	// A primary selection of 16 or more, or beyond the zone count, means
	// the maximum over all zones is used.
	assign primary_on   = (primary_q < PRIMARY_LIMIT) &&
	                      ({2'b0, primary_q} < 7'(ZONE_COUNT));
	assign reading_good = ok_s1 && ({3'b0, zone_s1} < 7'(ZONE_COUNT)) &&
	                      reading_s1 >= TEMP_LOW && reading_s1 <= TEMP_HIGH;
	assign is_primary   = primary_on && ({1'b0, zone_s1} == primary_q);

	// Accumulators as they stand once the stage-1 reading is folded in.
	always_comb begin
		rmax_nxt      = rmax_q;
		max_seen_nxt  = max_seen_q;
		prim_nxt      = prim_q;
		prim_seen_nxt = prim_seen_q;
		if (reading_good) begin
			if (!max_seen_q || reading_s1 > rmax_q) begin
				rmax_nxt     = reading_s1;
				max_seen_nxt = 1'b1;
			end
			if (is_primary) begin
				prim_nxt      = reading_s1;
				prim_seen_nxt = 1'b1;
			end
		end
	end

	// Temperature of the poll: primary zone first, then the maximum.
	always_comb begin
		chosen    = '0;
		chosen_ok = 1'b0;
		if (primary_on && prim_seen_nxt) begin
			chosen    = prim_nxt;
			chosen_ok = 1'b1;
		end else if (max_seen_nxt) begin
			chosen    = rmax_nxt;
			chosen_ok = 1'b1;
		end
	end

	tsh_classify u_classify (
		.temp      (temp_s2),
		.temp_ok   (temp_ok_s2),
		.level     (level_q),
		.thr       (thr_q),
		.hyst      (hyst_q),
		.last_temp (last_temp_q),
		.last_ok   (last_ok_q),
		.res       (cls_res)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVEL_COUNT; i++) begin
				thr_q[i] <= THR_DISABLED;
			end
			hyst_q    <= HYST_RESET;
			primary_q <= PRIMARY_RESET;
		end else if (cfg_wen) begin
			if (cfg_index < REG_HYSTERESIS) begin
				thr_q[cfg_index - REG_THR_LIGHT] <= cfg_wdata;
			end else if (cfg_index == REG_HYSTERESIS) begin
				hyst_q <= cfg_wdata[15:0];
			end else if (cfg_index == REG_PRIMARY) begin
				primary_q <= cfg_wdata[4:0];
			end
		end
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_vld_q   <= 1'b0;
			rmax_q      <= '0;
			max_seen_q  <= 1'b0;
			prim_q      <= '0;
			prim_seen_q <= 1'b0;
			level_q     <= 3'd0;
			last_temp_q <= '0;
			last_ok_q   <= 1'b1;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (rdy2) begin
				vld_s2 <= fire1 && last_s1;
			end
			if (rdy_out) begin
				out_vld_q <= vld_s2;
			end
			if (fire1) begin
				if (last_s1) begin
					rmax_q      <= '0;
					max_seen_q  <= 1'b0;
					prim_q      <= '0;
					prim_seen_q <= 1'b0;
				end else begin
					rmax_q      <= rmax_nxt;
					max_seen_q  <= max_seen_nxt;
					prim_q      <= prim_nxt;
					prim_seen_q <= prim_seen_nxt;
				end
			end
			if (fire2) begin
				level_q     <= cls_res.severity;
				last_temp_q <= temp_s2;
				last_ok_q   <= temp_ok_s2;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			zone_s1    <= s_tdata[3:0];
			reading_s1 <= s_tdata[22:4];
			ok_s1      <= s_tuser;
			last_s1    <= s_tlast;
		end
		if (fire1 && last_s1 && rdy2) begin
			temp_s2    <= chosen;
			temp_ok_s2 <= chosen_ok;
		end
		if (fire2) begin
			out_q <= cls_res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_q.notify, out_q.temp_milli, out_q.severity};
	assign m_tuser  = out_q.temp_valid;

endmodule

`default_nettype wire

// ----- rtl/core/tsh_checker.sv -----
// ----------------------------------------------------------------------------
// tsh_checker
// Port-level checks for the thermal severity hysteresis block.
// ----------------------------------------------------------------------------
`default_nettype none

module tsh_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire        m_tuser
);

	// A held result must stay offered until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	a_sev_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] != 3'd7)
		else $error("severity out of range");

	// With no temperature the severity and temperature are both zero.
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[2:0] == 3'd0 && m_tdata[21:3] == 19'd0)
		else $error("invalid temperature with nonzero result");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
		$signed(m_tdata[21:3]) >= -19'sd40000 && $signed(m_tdata[21:3]) <= 19'sd150000)
		else $error("temperature outside the accepted window");

endmodule

bind thermal_severity_hysteresis tsh_checker u_tsh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ----- bench/tsh_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// tsh_scoreboard_pkg
// Severity prediction and result checking for the thermal severity bench.
// ----------------------------------------------------------------------------

package tsh_scoreboard_pkg;

	import tsh_pkg::*;

	class severity_scoreboard;

		// Register image, index 0 of the threshold array is the implicit
		// severity-none floor and is never compared.
		milli_t      thr [0:LEVEL_COUNT];
		logic [15:0] hyst;
		logic [4:0]  primary;

		// Severity history and per-poll accumulators.
		logic [2:0]  level;
		int          last_temp;
		bit          last_ok;
		int          run_max;
		bit          max_seen;
		int          prim_temp;
		bit          prim_seen;

		tsh_result_t expected_polls [$];
		int          errors;
		int          polls_checked;

		function void reset_state();
			thr[0] = '0;
			for (int i = 1; i <= LEVEL_COUNT; i++)
				thr[i] = THR_DISABLED;
			hyst          = HYST_RESET;
			primary       = PRIMARY_RESET;
			level         = '0;
			last_temp     = 0;
			last_ok       = 1'b1;
			run_max       = 0;
			max_seen      = 1'b0;
			prim_temp     = 0;
			prim_seen     = 1'b0;
			errors        = 0;
			polls_checked = 0;
			expected_polls.delete();
		endfunction

		function int pending();
			return expected_polls.size();
		endfunction

		function void apply_config(logic [2:0] idx, logic [18:0] value);
			if (idx < REG_HYSTERESIS)
				thr[idx + 1] = milli_t'(value);
			else if (idx == REG_HYSTERESIS)
				hyst = value[15:0];
			else
				primary = value[4:0];
		endfunction

		function void note_reading(logic [3:0] zone, milli_t reading, logic ok, logic last);
			int          t;
			int          temp;
			bit          valid;
			bit          active;
			bit          notify;
			int          diff;
			logic [2:0]  sev;
			logic [2:0]  cur;
			tsh_result_t res;

			t      = int'(reading);
			temp   = 0;
			valid  = 1'b0;
			sev    = '0;
			active = (primary < PRIMARY_LIMIT) && (primary < ZONE_COUNT);

			if (ok && zone < ZONE_COUNT && t >= TEMP_LOW && t <= TEMP_HIGH) begin
				if (!max_seen || t > run_max) begin
					run_max  = t;
					max_seen = 1'b1;
				end
				if (active && zone == primary) begin
					prim_temp = t;
					prim_seen = 1'b1;
				end
			end
			if (!last)
				return;

			if (active && prim_seen) begin
				temp  = prim_temp;
				valid = 1'b1;
			end else if (max_seen) begin
				temp  = run_max;
				valid = 1'b1;
			end

			if (valid) begin
				for (int s = LEVEL_COUNT; s >= 1; s--) begin
					if (thr[s] != THR_DISABLED && temp >= thr[s]) begin
						sev = 3'(s);
						break;
					end
				end
				cur = (level > LEVEL_COUNT) ? 3'(LEVEL_COUNT) : level;
				if (sev < cur && thr[cur] != THR_DISABLED &&
				    temp >= int'(thr[cur]) - int'(hyst))
					sev = cur;
			end

			notify = (sev != level) || !last_ok;
			if (!notify && valid) begin
				diff = last_temp - temp;
				if (diff < 0)
					diff = -diff;
				if (diff >= NOTIFY_STEP)
					notify = 1'b1;
			end

			res.severity   = sev;
			res.temp_milli = milli_t'(temp);
			res.temp_valid = valid;
			res.notify     = notify;
			expected_polls.insert(expected_polls.size(), res);

			level     = sev;
			last_temp = valid ? temp : 0;
			last_ok   = valid;
			run_max   = 0;
			max_seen  = 1'b0;
			prim_temp = 0;
			prim_seen = 1'b0;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(tsh_result_t got);
			tsh_result_t want;
			if (expected_polls.size() == 0) begin
				report_mismatch($sformatf("result with no poll pending: severity %0d temp %0d",
					got.severity, got.temp_milli));
				return;
			end
			want = expected_polls.pop_front();
			if (got.severity !== want.severity)
				report_mismatch($sformatf("poll %0d severity: expected %0d got %0d",
					polls_checked, want.severity, got.severity));
			if (got.temp_milli !== want.temp_milli)
				report_mismatch($sformatf("poll %0d temp_milli: expected %0d got %0d",
					polls_checked, want.temp_milli, got.temp_milli));
			if (got.temp_valid !== want.temp_valid)
				report_mismatch($sformatf("poll %0d temp_valid: expected %0b got %0b",
					polls_checked, want.temp_valid, got.temp_valid));
			if (got.notify !== want.notify)
				report_mismatch($sformatf("poll %0d notify: expected %0b got %0b",
					polls_checked, want.notify, got.notify));
			polls_checked++;
		endtask

	endclass

endpackage

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stream-level bench for the thermal severity hysteresis block.
// ----------------------------------------------------------------------------
// Zone readings are pushed into the reading stream in polls, each closed by
// a transaction with s_tlast. Every accepted reading also goes to a
// scoreboard that predicts the per-poll result, and every result
// transaction is checked field by field against the oldest prediction.
// The run starts with a short directed sequence (range edges, hysteresis
// hold and release, primary capture) and continues with random polls under
// several register settings, with random idle cycles on both streams and
// one long receiver hold that backs the block up into its input.
// ----------------------------------------------------------------------------

module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import tsh_pkg::*;
	import tsh_scoreboard_pkg::*;

	// Register settings used by the phases of the run.
	typedef enum int {
		SET_RESET_VALUES,
		SET_FLOOR,
		SET_STEEP,
		SET_DIRECTED,
		SET_DIRECTED_PRIMARY,
		SET_RANDOM
	} setting_e;

	localparam int PHASE_ITEMS   = 94;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [18:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;

	severity_scoreboard sb = new;

	// Copy of the current register setting, used only to aim the random
	// temperatures at the interesting spots.
	int thr_sel [LEVEL_COUNT];
	int hyst_sel;
	int prim_sel;
	int prev_base;

	int items_sent;
	bit tx_quiet;
	bit rx_quiet;
	bit hold_request;

	thermal_severity_hysteresis dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [3:0] zone_index, [22:4] reading_milli, [23] zero
		.s_tuser   (s_tuser),   // [0] read_ok
		.s_tlast   (s_tlast),   // last_of_poll
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [2:0] severity, [21:3] temp_milli, [22] notify, [23] zero
		.m_tuser   (m_tuser)    // [0] temp_valid
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Idle lengths: mostly none or short, now and then a long one. A quiet
	// side never idles, which gives stretches of back-to-back traffic.
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// One register write per clock; the enable stays high across a burst
	// of writes and is lowered by the caller once the burst is done.
	task automatic write_reg(logic [2:0] idx, logic [18:0] value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		sb.apply_config(idx, value);
		@(posedge clk);
	endtask

	// Every phase rewrites all eight registers, so each register sees
	// every setting, including the extremes of its range.
	task automatic apply_setting(setting_e kind);
		int step;
		case (kind)
			SET_RESET_VALUES: begin
				foreach (thr_sel[i])
					thr_sel[i] = int'(THR_DISABLED);
				hyst_sel = int'(HYST_RESET);
				prim_sel = int'(PRIMARY_RESET);
			end
			SET_FLOOR: begin
				// Every level fires at the lowest legal temperature, and
				// with no hysteresis a drop is never held.
				foreach (thr_sel[i])
					thr_sel[i] = int'(TEMP_LOW);
				hyst_sel = 0;
				prim_sel = 0;
			end
			SET_STEEP: begin
				thr_sel[0] = int'($urandom_range(0, 30000)) - 40000;
				for (int i = 1; i < LEVEL_COUNT; i++) begin
					step       = $urandom_range(1000, 30000);
					thr_sel[i] = thr_sel[i-1] + step;
					if (thr_sel[i] > TEMP_HIGH)
						thr_sel[i] = int'(TEMP_HIGH);
				end
				hyst_sel = 65535;
				prim_sel = ZONE_COUNT - 1;
			end
			SET_DIRECTED, SET_DIRECTED_PRIMARY: begin
				for (int i = 0; i < LEVEL_COUNT; i++)
					thr_sel[i] = 40000 + 15000 * i;
				hyst_sel = int'(HYST_RESET);
				prim_sel = (kind == SET_DIRECTED_PRIMARY) ? 7 : int'(PRIMARY_RESET);
			end
			default: begin
				// Rising thresholds most of the time, an arbitrary order on
				// some phases, and each level disabled now and then.
				if ($urandom_range(0, 2) != 0) begin
					thr_sel[0] = int'($urandom_range(0, 60000)) - 40000;
					for (int i = 1; i < LEVEL_COUNT; i++) begin
						step       = $urandom_range(500, 25000);
						thr_sel[i] = thr_sel[i-1] + step;
						if (thr_sel[i] > TEMP_HIGH)
							thr_sel[i] = int'(TEMP_HIGH);
					end
				end else begin
					foreach (thr_sel[i])
						thr_sel[i] = int'($urandom_range(0, 190000)) - 40000;
				end
				foreach (thr_sel[i])
					if ($urandom_range(0, 4) == 0)
						thr_sel[i] = int'(THR_DISABLED);
				hyst_sel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
				                                       : $urandom_range(0, 6000);
				prim_sel = $urandom_range(0, PRIMARY_LIMIT);
			end
		endcase
		for (int i = 0; i < LEVEL_COUNT; i++)
			write_reg(REG_THR_LIGHT + 3'(i), 19'(thr_sel[i]));
		write_reg(REG_HYSTERESIS, 19'(hyst_sel));
		write_reg(REG_PRIMARY, 19'(prim_sel));
		cfg_wen <= 1'b0;
	endtask

	// Offers one reading after a random idle stretch and returns at the
	// edge where the transaction happens. While idle, the data lines carry
	// junk that the block has to ignore.
	task automatic send_reading(logic [3:0] zone, milli_t reading, logic ok, logic last);
		int gap;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 24'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, reading, zone};
		s_tuser  <= ok;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_reading(zone, reading, ok, last);
		items_sent++;
	endtask

	// A poll temperature aimed mostly at the threshold crossings and the
	// hysteresis band below them, sometimes close to the previous poll so
	// that the 500 millidegree notify step is hit from both sides.
	function automatic int pick_temp();
		int enabled [$];
		int r;
		int span;
		int val;
		foreach (thr_sel[i])
			if (thr_sel[i] != THR_DISABLED)
				enabled.insert(enabled.size(), thr_sel[i]);
		r = $urandom_range(0, 99);
		if (r < 60 && enabled.size() > 0) begin
			span = hyst_sel + 1500;
			val  = enabled[$urandom_range(0, enabled.size() - 1)];
			val  = val + int'($urandom_range(0, span + 1500)) - span;
		end else if (r < 78) begin
			val = prev_base + int'($urandom_range(0, 1400)) - 700;
		end else if (r < 93) begin
			val = int'($urandom_range(0, 190000)) - 40000;
		end else begin
			case ($urandom_range(0, 3))
				0:       val = int'(TEMP_LOW);
				1:       val = int'(TEMP_LOW) - 1;
				2:       val = int'(TEMP_HIGH);
				default: val = int'(TEMP_HIGH) + 1;
			endcase
		end
		return val;
	endfunction

	// One random poll: a short run of readings around a common temperature,
	// with the primary zone over-represented, some unread zones, some raw
	// 19-bit noise and now and then a poll in which nothing reads at all.
	task automatic send_poll();
		int         count;
		int         base;
		int         r;
		bit         dead;
		logic [3:0] zone;
		milli_t     reading;
		logic       ok;
		r = $urandom_range(0, 99);
		if (r < 80)
			count = $urandom_range(1, 4);
		else if (r < 97)
			count = $urandom_range(5, 12);
		else
			count = $urandom_range(13, 24);
		dead      = ($urandom_range(0, 99) < 6);
		base      = pick_temp();
		prev_base = base;
		for (int k = 0; k < count; k++) begin
			if (prim_sel < ZONE_COUNT && $urandom_range(0, 99) < 35)
				zone = 4'(prim_sel);
			else
				zone = 4'($urandom_range(0, ZONE_COUNT - 1));
			r = $urandom_range(0, 99);
			if (r < 8) begin
				reading = milli_t'($urandom);
				ok      = 1'($urandom_range(0, 1));
			end else begin
				reading = milli_t'(base + int'($urandom_range(0, 3000)) - 1500);
				ok      = (r >= 14);
			end
			if (k == 0 && $urandom_range(0, 9) == 0)
				reading = milli_t'(base);
			if (dead)
				ok = 1'b0;
			send_reading(zone, reading, ok, (k == count - 1));
		end
	endtask

	// Lets every outstanding poll result come out, then a few more cycles
	// so the pipeline is empty before the registers are touched.
	task automatic drain_results();
		int waited;
		waited   = 0;
		s_tvalid <= 1'b0;
		while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: random ready bursts and idle stretches, plus one long hold
	// on request, counted here while the sender keeps offering readings.
	initial begin : receiver
		int busy;
		int gap;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				busy = $urandom_range(1, 12);
				gap  = pick_gap(rx_quiet);
				m_tready <= 1'b1;
				repeat (busy) @(posedge clk);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Result monitor. Sampling at the edge sees the values from just before
	// it, which is exactly the transaction that the edge completes.
	always @(posedge clk) begin : result_monitor
		tsh_result_t observed;
		if (m_tvalid && m_tready) begin
			observed.severity   = m_tdata[2:0];
			observed.temp_milli = m_tdata[21:3];
			observed.notify     = m_tdata[22];
			observed.temp_valid = m_tuser;
			sb.check_result(observed);
		end
	end

	initial begin : main_sequence
		setting_e phase_plan [8];
		int       target;

		phase_plan = '{SET_RESET_VALUES, SET_FLOOR, SET_STEEP, SET_RANDOM,
		               SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_RANDOM};
		sb.reset_state();
		items_sent   = 0;
		tx_quiet     = 1'b0;
		rx_quiet     = 1'b0;
		hold_request = 1'b0;
		prev_base    = 25000;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed polls against evenly spaced thresholds 40..115 degrees.
		apply_setting(SET_DIRECTED);
		send_reading(4'd0, 19'sd150000, 1'b1, 1'b1);   // hottest legal reading
		send_reading(4'd1, -19'sd40000, 1'b1, 1'b1);   // coldest, falls far past the band
		send_reading(4'd2, 19'sd150001, 1'b1, 1'b1);   // just above range, no temperature
		send_reading(4'd3, -19'sd40001, 1'b1, 1'b1);   // just below range, previous invalid
		send_reading(4'd4, 19'sd50000, 1'b0, 1'b1);    // zone failed to read
		send_reading(4'd5, 19'sh40000, 1'b1, 1'b0);    // most negative raw value
		send_reading(4'd6, 19'sd262143, 1'b1, 1'b0);   // most positive raw value
		send_reading(4'd15, 19'sd60000, 1'b1, 1'b1);   // last zone, lands on moderate
		send_reading(4'd9, 19'sd54000, 1'b1, 1'b1);    // inside the band, level held
		send_reading(4'd10, 19'sd54200, 1'b1, 1'b1);   // held, too small a move to notify
		send_reading(4'd11, 19'sd52999, 1'b1, 1'b1);   // leaves the band, drops to light
		send_reading(4'd5, 19'sd45000, 1'b1, 1'b0);
		send_reading(4'd6, 19'sd80000, 1'b0, 1'b0);    // unread hot zone does not count
		send_reading(4'd7, 19'sd71000, 1'b1, 1'b0);
		send_reading(4'd8, 19'sd30000, 1'b1, 1'b1);    // maximum of the poll wins
		drain_results();

		// Same thresholds with zone 7 as the primary sensor.
		apply_setting(SET_DIRECTED_PRIMARY);
		send_reading(4'd7, 19'sd60000, 1'b1, 1'b0);
		send_reading(4'd3, 19'sd90000, 1'b1, 1'b0);
		send_reading(4'd7, 19'sd62000, 1'b1, 1'b0);    // later primary reading is kept
		send_reading(4'd9, -19'sd10000, 1'b1, 1'b1);
		send_reading(4'd2, 19'sd41000, 1'b1, 1'b0);
		send_reading(4'd7, 19'sd50000, 1'b0, 1'b1);    // primary unread, falls back to max
		send_reading(4'd7, 19'sd150001, 1'b1, 1'b1);   // primary out of range, nothing else
		send_reading(4'd7, 19'sd120000, 1'b1, 1'b1);   // top level, disabled by the next phase
		drain_results();

		// Random phases. The fourth one holds the receiver off for a long
		// stretch with a sender that never idles, so the block backs up;
		// the sixth runs both sides without any idle cycles.
		foreach (phase_plan[p]) begin
			apply_setting(phase_plan[p]);
			tx_quiet = (p == 3) || (p == 5);
			rx_quiet = (p == 5);
			if (p == 3)
				hold_request = 1'b1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				send_poll();
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d poll results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin : watchdog
		#1ms;
		$display("tb: errors");
		$finish;
	end

endmodule
